// File: sv/cosine_similarity_score_core_defines.svh
// Assertion macros shared by the cosine similarity score RTL
`ifndef COSINE_SIMILARITY_SCORE_CORE_DEFINES_SVH
`define COSINE_SIMILARITY_SCORE_CORE_DEFINES_SVH

// condition holds in the same cycle
`define CSS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// condition holds in the cycle after the antecedent
`define CSS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/css_pkg.sv
// Shared types and constants of the cosine similarity score block
package css_pkg;

    localparam int ACC_BITS  = 44;
    localparam int PROD_BITS = 2 * ACC_BITS;
    localparam int CFG_BITS  = 16;
    localparam int SRCH_BITS = 124;

    localparam logic REG_CENTER_OFFSET = 1'b0;
    localparam logic REG_INVERSE_RANGE = 1'b1;

    localparam logic signed [CFG_BITS-1:0] CENTER_OFFSET_RST = 16'sd12117;
    localparam logic [CFG_BITS-1:0]        INVERSE_RANGE_RST = 16'd10923;

    typedef struct packed {
        logic signed [ACC_BITS-1:0] dot;
        logic [ACC_BITS-1:0]        norm_a;
        logic [ACC_BITS-1:0]        norm_b;
    } acc_snap_t;

    typedef struct packed {
        logic      valid;
        acc_snap_t data;
    } snap_port_t;

endpackage

// File: sv/css_front.sv
// Front end: saturating multiply-accumulate of element pairs, snapshot on last
module css_front #(
    parameter int ELEMENT_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic signed [ELEMENT_BITS-1:0] a_element,
    input  logic signed [ELEMENT_BITS-1:0] b_element,
    input  logic                           last,
    output logic                           snap_push,
    output css_pkg::acc_snap_t             snap_data
);

    localparam int PW = 2 * ELEMENT_BITS;
    localparam int SW = ((PW > css_pkg::ACC_BITS) ? PW : css_pkg::ACC_BITS) + 2;
    localparam logic signed [SW-1:0] DOT_MAX = (SW'(1) <<< (css_pkg::ACC_BITS - 1)) - SW'(1);
    localparam logic signed [SW-1:0] DOT_MIN = -DOT_MAX - SW'(1);
    localparam logic [SW-1:0]        NORM_MAX = (SW'(1) << css_pkg::ACC_BITS) - SW'(1);

    logic signed [css_pkg::ACC_BITS-1:0] dot_reg, dot_next;
    logic [css_pkg::ACC_BITS-1:0]        na_reg, na_next;
    logic [css_pkg::ACC_BITS-1:0]        nb_reg, nb_next;

    logic signed [PW-1:0] prod_ab, prod_aa, prod_bb;
    logic signed [SW-1:0] dot_wide;
    logic [SW-1:0]        na_wide, nb_wide;
    logic signed [css_pkg::ACC_BITS-1:0] dot_sat;
    logic [css_pkg::ACC_BITS-1:0]        na_sat, nb_sat;

    always_comb
    begin
        prod_ab  = a_element * b_element;
        prod_aa  = a_element * a_element;
        prod_bb  = b_element * b_element;
        dot_wide = SW'(dot_reg) + SW'(prod_ab);
        na_wide  = SW'(na_reg) + SW'($unsigned(prod_aa));
        nb_wide  = SW'(nb_reg) + SW'($unsigned(prod_bb));

        if (dot_wide > DOT_MAX)
            dot_sat = DOT_MAX[css_pkg::ACC_BITS-1:0];
        else if (dot_wide < DOT_MIN)
            dot_sat = DOT_MIN[css_pkg::ACC_BITS-1:0];
        else
            dot_sat = dot_wide[css_pkg::ACC_BITS-1:0];
        na_sat = (na_wide > NORM_MAX) ? NORM_MAX[css_pkg::ACC_BITS-1:0]
                                      : na_wide[css_pkg::ACC_BITS-1:0];
        nb_sat = (nb_wide > NORM_MAX) ? NORM_MAX[css_pkg::ACC_BITS-1:0]
                                      : nb_wide[css_pkg::ACC_BITS-1:0];

        snap_push        = accept && last;
        snap_data.dot    = dot_sat;
        snap_data.norm_a = na_sat;
        snap_data.norm_b = nb_sat;

        dot_next = dot_reg;
        na_next  = na_reg;
        nb_next  = nb_reg;
        if (accept)
        begin
            if (last)
            begin
                dot_next = '0;
                na_next  = '0;
                nb_next  = '0;
            end
            else
            begin
                dot_next = dot_sat;
                na_next  = na_sat;
                nb_next  = nb_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg <= '0;
            na_reg  <= '0;
            nb_reg  <= '0;
        end
        else
        begin
            dot_reg <= dot_next;
            na_reg  <= na_next;
            nb_reg  <= nb_next;
        end
    end

endmodule

// File: sv/css_queue.sv
// Short queue of accumulator snapshots between front and back end
`include "cosine_similarity_score_core_defines.svh"

module css_queue #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  css_pkg::acc_snap_t  wdata,
    output logic                full,
    input  logic                take,
    output css_pkg::snap_port_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    css_pkg::acc_snap_t slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    always_comb
    begin
        full       = (count_reg == CNT_W'(DEPTH));
        head.valid = (count_reg != '0);
        head.data  = slot_reg[rd_ptr_reg];
        do_push    = push && !full;
        do_pop     = take && head.valid;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `CSS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH))
    `CSS_ASSERT_NEXT(a_count_up, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1)
    `CSS_ASSERT_NEXT(a_count_down, do_pop && !do_push, count_reg == $past(count_reg) - 1'b1)

endmodule

// File: sv/css_back.sv
// Back end: cosine by bitwise search over shared partial products, then score
`include "cosine_similarity_score_core_defines.svh"

module css_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  css_pkg::snap_port_t                   head,
    output logic                                  take,
    input  logic signed [css_pkg::CFG_BITS-1:0]   center_offset,
    input  logic [css_pkg::CFG_BITS-1:0]          inverse_range,
    input  logic                                  pop,
    output logic                                  empty,
    output logic [15:0]                           similarity,
    output logic signed [15:0]                    cosine,
    output logic                                  zero_norm
);

    localparam int AB = css_pkg::ACC_BITS;
    localparam int HB = AB / 2;
    localparam int PB = css_pkg::PROD_BITS;
    localparam int XB = css_pkg::SRCH_BITS;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MUL   = 8'b0000_0010,
        ST_INIT  = 8'b0000_0100,
        ST_TRY_A = 8'b0000_1000,
        ST_TRY_B = 8'b0001_0000,
        ST_SCALE = 8'b0010_0000,
        ST_SCORE = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } back_state_t;

    back_state_t state_reg, state_next;

    logic [AB-1:0]          na_reg, nb_reg, mag_reg;
    logic                   neg_reg;
    logic [2:0]             cnt_reg;
    logic [PB-1:0]          p_reg, r_reg;
    logic signed [XB-1:0]   x_reg, q_reg, h_reg, s_reg;
    logic [15:0]            c_reg;
    logic [3:0]             bit_reg;
    logic signed [15:0]     cos_reg;
    logic signed [33:0]     prod_reg;
    logic [15:0]            sim_reg;
    logic                   zn_reg;

    logic [AB-1:0]          op_x, op_y;
    logic [HB-1:0]          half_x, half_y;
    logic [PB-1:0]          term, acc_base;
    logic signed [XB-1:0]   x_try, r_cmp;
    logic [16:0]            lo;
    logic signed [16:0]     cos_wide;
    logic signed [16:0]     diff;
    logic signed [34:0]     t_val;
    logic [22:0]            t_round;
    logic                   head_zero;

    always_comb
    begin
        op_x   = cnt_reg[2] ? mag_reg : na_reg;
        op_y   = cnt_reg[2] ? mag_reg : nb_reg;
        half_x = cnt_reg[0] ? op_x[AB-1:HB] : op_x[HB-1:0];
        half_y = cnt_reg[1] ? op_y[AB-1:HB] : op_y[HB-1:0];
        term   = PB'(half_x * half_y);
        unique case (cnt_reg[1:0])
            2'b00:        term = term;
            2'b01, 2'b10: term = term << HB;
            default:      term = term << (2 * HB);
        endcase
        if (cnt_reg[1:0] == 2'b00)
            acc_base = '0;
        else
            acc_base = cnt_reg[2] ? r_reg : p_reg;

        x_try = s_reg + h_reg;
        r_cmp = $signed({{(XB - PB - 32){1'b0}}, r_reg, 32'b0});

        lo       = c_reg[15] ? 17'h08000 : {1'b0, c_reg};
        cos_wide = neg_reg ? -$signed(lo) : $signed(lo);
        if (cos_wide > 17'sd32767)
            cos_wide = 17'sd32767;
        diff = 17'(cos_wide) - 17'(center_offset);

        t_val   = 35'sd268435456 + 35'(prod_reg);
        t_round = 23'((t_val + 35'sd4096) >>> 13);

        head_zero = (head.data.norm_a == '0) || (head.data.norm_b == '0);
        take      = (state_reg == ST_IDLE) && head.valid;

        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (head.valid) state_next = head_zero ? ST_DONE : ST_MUL;
            ST_MUL:   if (cnt_reg == 3'd7) state_next = ST_INIT;
            ST_INIT:  state_next = ST_TRY_A;
            ST_TRY_A: state_next = ST_TRY_B;
            ST_TRY_B: state_next = (bit_reg == 4'd0) ? ST_SCALE : ST_TRY_A;
            ST_SCALE: state_next = ST_SCORE;
            ST_SCORE: state_next = ST_DONE;
            ST_DONE:  if (pop) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase

        empty      = (state_reg != ST_DONE);
        similarity = sim_reg;
        cosine     = cos_reg;
        zero_norm  = zn_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                na_reg  <= head.data.norm_a;
                nb_reg  <= head.data.norm_b;
                neg_reg <= head.data.dot[AB-1];
                mag_reg <= head.data.dot[AB-1] ? AB'(-head.data.dot) : AB'(head.data.dot);
                cnt_reg <= '0;
                sim_reg <= '0;
                cos_reg <= '0;
                zn_reg  <= head_zero;
            end
            ST_MUL:
            begin
                if (cnt_reg[2])
                    r_reg <= acc_base + term;
                else
                    p_reg <= acc_base + term;
                cnt_reg <= cnt_reg + 1'b1;
            end
            ST_INIT:
            begin
                // start at c = 0, k = 2c-1 = -1
                x_reg   <= XB'(p_reg);
                q_reg   <= XB'(p_reg) <<< 32;
                h_reg   <= -(XB'(p_reg) <<< 17);
                c_reg   <= '0;
                bit_reg <= 4'd15;
            end
            ST_TRY_A:
                s_reg <= x_reg + q_reg;
            ST_TRY_B:
            begin
                if (x_try <= r_cmp)
                begin
                    x_reg          <= x_try;
                    c_reg[bit_reg] <= 1'b1;
                    h_reg          <= (h_reg >>> 1) + q_reg;
                end
                else
                    h_reg <= h_reg >>> 1;
                q_reg   <= q_reg >>> 2;
                bit_reg <= bit_reg - 1'b1;
            end
            ST_SCALE:
            begin
                cos_reg  <= cos_wide[15:0];
                prod_reg <= 34'(diff * $signed({1'b0, inverse_range}));
            end
            ST_SCORE:
            begin
                if (t_val < 0)
                    sim_reg <= '0;
                else if (t_round > 23'd65535)
                    sim_reg <= 16'hFFFF;
                else
                    sim_reg <= t_round[15:0];
            end
            ST_DONE:
                sim_reg <= sim_reg;
            default:
                cnt_reg <= cnt_reg;
        endcase
    end

    `CSS_ASSERT_NEXT(a_hold_result, state_reg == ST_DONE && !pop, state_reg == ST_DONE)
    `CSS_ASSERT_NOW(a_zero_norm_result, state_reg == ST_DONE && zn_reg,
                    sim_reg == '0 && cos_reg == '0)
    `CSS_ASSERT_NEXT(a_start, state_reg == ST_IDLE && head.valid, state_reg != ST_IDLE)

endmodule

// File: sv/cosine_similarity_score_core.sv
// Top level of the cosine similarity score block
//
// Input side is a queue write port: drive a_element, b_element and last with
// push; a pair is taken on a clock edge with push high and full low. One pair
// per cycle is accumulated while full is low (dot product and both squared
// norms, saturating). The pair with last high closes the vector and queues
// a snapshot of the sums. Result side is a queue read port: while empty is
// low, similarity, cosine and zero_norm hold the oldest result; it is taken
// on an edge with pop high. For each vector the snapshot is handed to the
// back end, the shared 22x22 multiplier forms the two wide products, the
// search is set up, a per-bit cosine search runs with a trial and a compare
// state per bit, and the score is computed. A zero-norm vector goes straight
// to its result. The back end takes a new snapshot only after its last result
// is popped, so full rises only when QUEUE_DEPTH closed vectors wait on the
// back end.
// A stalled pop holds the result and the back end; the front accepts while full is low.
// Reset clears the sums and the queue and loads the register defaults.
// Registers (wr_en, wr_index, wr_data): 0 center_offset, 1 inverse_range.
module cosine_similarity_score_core #(
    parameter int ELEMENT_BITS = 16,
    parameter int QUEUE_DEPTH  = 2
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic signed [ELEMENT_BITS-1:0]       a_element,
    input  logic signed [ELEMENT_BITS-1:0]       b_element,
    input  logic                                 last,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [15:0]                          similarity,
    output logic signed [15:0]                   cosine,
    output logic                                 zero_norm,
    input  logic                                 wr_en,
    input  logic                                 wr_index,
    input  logic [css_pkg::CFG_BITS-1:0]         wr_data
);

    logic signed [css_pkg::CFG_BITS-1:0] center_offset_reg;
    logic [css_pkg::CFG_BITS-1:0]        inverse_range_reg;

    logic                accept;
    logic                snap_push;
    css_pkg::acc_snap_t  snap_data;
    css_pkg::snap_port_t head;
    logic                take;

    assign accept = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_offset_reg <= css_pkg::CENTER_OFFSET_RST;
            inverse_range_reg <= css_pkg::INVERSE_RANGE_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                css_pkg::REG_CENTER_OFFSET: center_offset_reg <= $signed(wr_data);
                css_pkg::REG_INVERSE_RANGE: inverse_range_reg <= wr_data;
                default:                    inverse_range_reg <= inverse_range_reg;
            endcase
        end
    end

    css_front #(
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .a_element (a_element),
        .b_element (b_element),
        .last      (last),
        .snap_push (snap_push),
        .snap_data (snap_data)
    );

    css_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (snap_push),
        .wdata (snap_data),
        .full  (full),
        .take  (take),
        .head  (head)
    );

    css_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .take          (take),
        .center_offset (center_offset_reg),
        .inverse_range (inverse_range_reg),
        .pop           (pop),
        .empty         (empty),
        .similarity    (similarity),
        .cosine        (cosine),
        .zero_norm     (zero_norm)
    );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the cosine similarity score core
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  MAX_CYCLES = 3000000;
    localparam int  DRAIN_WAIT = 80;
    localparam int  MODE_RAND  = 0;
    localparam int  MODE_SMALL = 1;
    localparam int  MODE_SAME  = 2;
    localparam int  MODE_NEG   = 3;
    localparam int  MODE_ZERO_A = 4;
    localparam int  MODE_ZERO_B = 5;
    localparam int  MODE_EXTREME = 6;

    typedef struct {
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic               last;
    } pair_t;

    typedef struct {
        logic [15:0]        similarity;
        logic signed [15:0] cosine;
        logic               zero_norm;
    } score_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic signed [15:0] a_element = '0;
    logic signed [15:0] b_element = '0;
    logic last = 1'b0;
    logic empty;
    logic pop = 1'b0;
    logic [15:0] similarity;
    logic signed [15:0] cosine;
    logic zero_norm;
    logic wr_en = 1'b0;
    logic wr_index = 1'b0;
    logic [css_pkg::CFG_BITS-1:0] wr_data = '0;

    pair_t  pending_pairs[$];
    score_t expected_scores[$];
    longint dot_acc, norm_a_acc, norm_b_acc;
    longint offset_reg, inv_range_reg;
    bit     pair_taken = 1'b0;
    bit     idle_on = 1'b1;
    bit     sender_hold = 1'b0;
    int     send_gap = 0;
    int     pop_gap = 0;
    int     errors = 0;
    int     cycles = 0;

    cosine_similarity_score_core dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .a_element(a_element), .b_element(b_element), .last(last),
        .empty(empty), .pop(pop), .similarity(similarity), .cosine(cosine),
        .zero_norm(zero_norm), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint sat(longint v, longint lo, longint hi);
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    // largest c in [0,32768] with (2c-1)^2 * na*nb <= 2^32 * dot^2
    function automatic score_t score_of(longint d, longint na, longint nb);
        score_t r;
        logic [127:0] pn, rhs, mag;
        logic [63:0] k;
        longint lo, hi, mid, cv, t, s;
        r.zero_norm = 1'b0;
        if (na == 0 || nb == 0)
        begin
            r.similarity = '0;
            r.cosine = '0;
            r.zero_norm = 1'b1;
            return r;
        end
        mag = (d < 0) ? 128'(-d) : 128'(d);
        pn = 128'(na) * 128'(nb);
        rhs = (mag * mag) << 32;
        lo = 0;
        hi = 32768;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            k = 64'(2 * mid - 1);
            if (128'(k * k) * pn <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        cv = (d < 0) ? -lo : lo;
        if (cv > 32767)
            cv = 32767;
        t = (longint'(1) << 28) + (cv - offset_reg) * inv_range_reg;
        s = (t < 0) ? 0 : ((t + 4096) >>> 13);
        if (s > 65535)
            s = 65535;
        r.similarity = 16'(s);
        r.cosine = 16'(cv);
        return r;
    endfunction

    task automatic accumulate_pair(pair_t p);
        longint av, bv;
        av = p.a;
        bv = p.b;
        dot_acc = sat(dot_acc + av * bv, -(longint'(1) << 43), (longint'(1) << 43) - 1);
        norm_a_acc = sat(norm_a_acc + av * av, 0, (longint'(1) << 44) - 1);
        norm_b_acc = sat(norm_b_acc + bv * bv, 0, (longint'(1) << 44) - 1);
        if (p.last)
        begin
            expected_scores.push_back(score_of(dot_acc, norm_a_acc, norm_b_acc));
            dot_acc = 0;
            norm_a_acc = 0;
            norm_b_acc = 0;
        end
    endtask

    // sample side: accepted words and result checks
    always @(posedge clk)
    begin
        pair_t p;
        score_t e;
        cycles <= cycles + 1;
        pair_taken <= rst_n && push && !full;
        if (rst_n && push && !full)
        begin
            p.a = a_element;
            p.b = b_element;
            p.last = last;
            accumulate_pair(p);
        end
        if (rst_n && pop && !empty)
        begin
            if (expected_scores.size() == 0)
            begin
                $display("%0t: unexpected result sim=%0d cos=%0d zn=%0b",
                         $time, similarity, cosine, zero_norm);
                errors = errors + 1;
            end
            else
            begin
                e = expected_scores.pop_front();
                if (similarity !== e.similarity)
                begin
                    $display("%0t: similarity expected %0d actual %0d",
                             $time, e.similarity, similarity);
                    errors = errors + 1;
                end
                if (cosine !== e.cosine)
                begin
                    $display("%0t: cosine expected %0d actual %0d", $time, e.cosine, cosine);
                    errors = errors + 1;
                end
                if (zero_norm !== e.zero_norm)
                begin
                    $display("%0t: zero_norm expected %0b actual %0b",
                             $time, e.zero_norm, zero_norm);
                    errors = errors + 1;
                end
            end
        end
        if (cycles >= MAX_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // pair driver
    always @(negedge clk)
    begin
        pair_t p;
        if (rst_n && (!push || pair_taken))
        begin
            if (send_gap > 0)
            begin
                push <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_pairs.size() > 0 && !sender_hold)
            begin
                p = pending_pairs.pop_front();
                a_element <= p.a;
                b_element <= p.b;
                last <= p.last;
                push <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0)
                    send_gap <= $urandom_range(1, 4);
            end
            else
                push <= 1'b0;
        end
    end

    // result reader
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (pop_gap > 0)
            begin
                pop <= 1'b0;
                pop_gap <= pop_gap - 1;
            end
            else
            begin
                pop <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0)
                    pop_gap <= $urandom_range(1, 4);
            end
        end
    end

    function automatic logic signed [15:0] element_for(int mode);
        case (mode)
            MODE_SMALL: return 16'($signed($urandom_range(0, 15)) - 8);
            MODE_EXTREME: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_vector(int len, int mode);
        pair_t p;
        for (int i = 0; i < len; i++)
        begin
            p.a = element_for(mode);
            p.b = element_for(mode);
            if (mode == MODE_SAME)
                p.b = p.a;
            if (mode == MODE_NEG)
                p.b = -p.a;
            if (mode == MODE_ZERO_A)
                p.a = '0;
            if (mode == MODE_ZERO_B)
                p.b = '0;
            p.last = (i == len - 1);
            pending_pairs.push_back(p);
        end
    endtask

    task automatic add_pair(logic signed [15:0] a, logic signed [15:0] b, logic l);
        pair_t p;
        p.a = a;
        p.b = b;
        p.last = l;
        pending_pairs.push_back(p);
    endtask

    task automatic drain();
        wait (pending_pairs.size() == 0 && !push && expected_scores.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(negedge clk);
        wr_en <= 1'b0;
        if (idx == css_pkg::REG_CENTER_OFFSET)
            offset_reg = longint'($signed(val));
        else
            inv_range_reg = longint'(val);
    endtask

    task automatic random_vectors(int items);
        int n, len, mode;
        n = 0;
        while (n < items)
        begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 10);
            mode = $urandom_range(0, 9);
            if (mode > MODE_EXTREME)
                mode = MODE_RAND;
            add_vector(len, mode);
            n += len;
        end
    endtask

    initial
    begin
        dot_acc = 0;
        norm_a_acc = 0;
        norm_b_acc = 0;
        offset_reg = css_pkg::CENTER_OFFSET_RST;
        inv_range_reg = css_pkg::INVERSE_RANGE_RST;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, cosine of one and minus one, zero norms
        add_pair(16'sh7fff, 16'sh7fff, 1'b1);
        add_pair(16'sh8000, 16'sh8000, 1'b1);
        add_pair(16'sh8000, 16'sh7fff, 1'b1);
        add_pair(16'sh7fff, 16'sh8000, 1'b1);
        add_pair(16'sh0000, 16'sh1234, 1'b1);
        add_pair(16'sh4321, 16'sh0000, 1'b1);
        add_pair(16'sh0000, 16'sh0000, 1'b1);
        add_pair(16'sh0001, 16'shffff, 1'b1);
        add_pair(16'sh1000, 16'sh0000, 1'b0);
        add_pair(16'sh0000, 16'sh1000, 1'b1);
        add_vector(4, MODE_SAME);
        add_vector(4, MODE_NEG);
        add_vector(3, MODE_RAND);
        drain();

        sender_hold = 1'b0;
        random_vectors(200);
        drain();

        write_reg(css_pkg::REG_CENTER_OFFSET, 16'h8000);
        write_reg(css_pkg::REG_INVERSE_RANGE, 16'h0000);
        random_vectors(250);
        drain();

        write_reg(css_pkg::REG_CENTER_OFFSET, 16'h7fff);
        write_reg(css_pkg::REG_INVERSE_RANGE, 16'hffff);
        random_vectors(250);
        // sender waits until every result is in, then resumes
        sender_hold = 1'b1;
        wait (expected_scores.size() == 0 && !push);
        random_vectors(50);
        sender_hold = 1'b0;
        drain();

        write_reg(css_pkg::REG_CENTER_OFFSET, 16'h8000);
        write_reg(css_pkg::REG_INVERSE_RANGE, 16'hffff);
        random_vectors(250);
        drain();

        write_reg(css_pkg::REG_CENTER_OFFSET, 16'($urandom));
        write_reg(css_pkg::REG_INVERSE_RANGE, 16'($urandom));
        random_vectors(250);
        drain();

        idle_on = 1'b0;
        write_reg(css_pkg::REG_CENTER_OFFSET, 16'($urandom));
        write_reg(css_pkg::REG_INVERSE_RANGE, 16'($urandom_range(8000, 20000)));
        random_vectors(250);
        drain();

        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
